FILE: hdl/bounded_vector_with_sort_macros.svh
// ----------------------------------------------------------------------------
// bounded_vector_with_sort_macros
// Assertion macros used by the checker.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_VECTOR_WITH_SORT_MACROS_SVH
`define BOUNDED_VECTOR_WITH_SORT_MACROS_SVH
// Assert a property on every rising clock edge outside reset.
`define BVS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a condition implies another in the same cycle, outside reset.
`define BVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`endif

FILE: hdl/bvs_pkg.sv
// ----------------------------------------------------------------------------
// bvs_pkg
// Types and constants for the bounded list with sort.
// ----------------------------------------------------------------------------
package bvs_pkg;
  localparam int unsigned Capacity = 256;
  localparam int unsigned IdxW = $clog2(Capacity);
  localparam int unsigned CntW = IdxW + 1;

  typedef enum logic [2:0] {
    FUNC_TAIL   = 3'd0,
    FUNC_HEAD   = 3'd1,
    FUNC_AFTER  = 3'd2,
    FUNC_REMOVE = 3'd3,
    FUNC_READ   = 3'd4,
    FUNC_CLEAR  = 3'd5,
    FUNC_SORT   = 3'd6
  } func_e;

  typedef struct packed {
    logic [2:0]         func;
    logic [7:0]         position;
    logic signed [31:0] data_in;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic signed [31:0] data_out;
    logic [8:0]         entries_used;
  } rsp_t;
endpackage

FILE: hdl/bounded_vector_with_sort.sv
// Clear and failed requests go from decode straight to the result; a read adds a RAM
// read state. Insert and remove move one entry at a time through the single RAM port,
// a read state then a write state per entry; sort is an insertion sort on that port.
// One request at a time: busy is held through the result cycle, so the next request is taken only after it.
// Results are strobed one cycle by done_o; the receiver cannot stall.
// Reset clears the count and control; stored entries are undefined until written.
// ----------------------------------------------------------------------------
// bounded_vector_with_sort
// Fixed-capacity list in a one-port RAM, shifted and sorted by a sequencer.
// ----------------------------------------------------------------------------
module bounded_vector_with_sort (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  bvs_pkg::req_t req_i,
  output logic          busy,
  output logic          done_o,
  output bvs_pkg::rsp_t rsp_o
);
  localparam int unsigned IW = bvs_pkg::IdxW;
  localparam int unsigned CW = bvs_pkg::CntW;

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_UP_RD, S_UP_WR, S_DN_RD, S_DN_WR, S_PUT, S_RD,
    S_SO_KEY, S_SO_CMP, S_SO_WR, S_DONE
  } state_e;

  state_e              state_q;
  logic [CW-1:0]       count_q;
  logic [CW-1:0]       i_q, j_q, at_q;
  logic [2:0]          func_q;
  logic [7:0]          pos_q;
  logic signed [31:0]  val_q, key_q;
  logic                ok_q;
  logic signed [31:0]  rdo_q;
  logic                done_q;

  // single-port RAM, registered read
  logic [31:0]         mem [bvs_pkg::Capacity];
  logic [31:0]         rdata_q;
  logic                we;
  logic [IW-1:0]       addr;
  logic [31:0]         wdata;

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wdata;
    rdata_q <= mem[addr];
  end

  logic full;
  logic pos_ok;
  logic so_shift;
  assign full     = (count_q == CW'(bvs_pkg::Capacity));
  assign pos_ok   = (CW'(pos_q) < count_q);
  // predecessor smaller than the key: move it up one slot
  assign so_shift = (j_q != '0) && ($signed(rdata_q) < key_q);

  // address and write decode per state
  always_comb begin
    we = 1'b0; addr = i_q[IW-1:0]; wdata = rdata_q;
    case (state_q)
      S_UP_RD:  addr = IW'(i_q - CW'(1));
      S_UP_WR:  begin we = 1'b1; addr = i_q[IW-1:0]; end
      S_DN_RD:  addr = IW'(i_q + CW'(1));
      S_DN_WR:  begin we = 1'b1; addr = i_q[IW-1:0]; end
      S_PUT:    begin we = 1'b1; addr = at_q[IW-1:0]; wdata = val_q; end
      S_RD:     addr = IW'(pos_q);
      S_SO_KEY: addr = i_q[IW-1:0];
      S_SO_CMP: addr = IW'(j_q - CW'(1));
      S_SO_WR:  begin
        we = 1'b1; addr = j_q[IW-1:0];
        wdata = so_shift ? rdata_q : key_q;
      end
      default:  ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; count_q <= '0; done_q <= 1'b0;
      ok_q <= 1'b0; rdo_q <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        S_IDLE: if (start && !busy) begin
          func_q <= req_i.func; pos_q <= req_i.position; val_q <= req_i.data_in;
          state_q <= S_DEC;
        end
        S_DEC: begin
          ok_q <= 1'b0; rdo_q <= '0; state_q <= S_DONE;
          case (func_q)
            bvs_pkg::FUNC_TAIL, bvs_pkg::FUNC_HEAD, bvs_pkg::FUNC_AFTER:
              if (!full && (func_q != bvs_pkg::FUNC_AFTER || pos_ok)) begin
                at_q <= (func_q == bvs_pkg::FUNC_TAIL) ? count_q :
                        (func_q == bvs_pkg::FUNC_HEAD) ? '0 : CW'(pos_q) + CW'(1);
                i_q <= count_q; state_q <= S_UP_RD;
              end
            bvs_pkg::FUNC_REMOVE: if (pos_ok) begin
              i_q <= CW'(pos_q); state_q <= S_DN_RD;
            end
            bvs_pkg::FUNC_READ: if (pos_ok) state_q <= S_RD;
            bvs_pkg::FUNC_CLEAR: begin count_q <= '0; ok_q <= 1'b1; end
            bvs_pkg::FUNC_SORT: begin i_q <= CW'(1); state_q <= S_SO_KEY; end
            default: ;
          endcase
        end
        // open a gap: move entry i-1 up to i until i reaches the slot
        S_UP_RD: state_q <= (i_q > at_q) ? S_UP_WR : S_PUT;
        S_UP_WR: begin i_q <= i_q - CW'(1); state_q <= S_UP_RD; end
        S_PUT: begin count_q <= count_q + CW'(1); ok_q <= 1'b1; state_q <= S_DONE; end
        // close a gap: move entry i+1 down to i
        S_DN_RD: begin
          if (i_q + CW'(1) < count_q) state_q <= S_DN_WR;
          else begin count_q <= count_q - CW'(1); ok_q <= 1'b1; state_q <= S_DONE; end
        end
        S_DN_WR: begin i_q <= i_q + CW'(1); state_q <= S_DN_RD; end
        S_RD: begin ok_q <= 1'b1; state_q <= S_DONE; end
        // insertion sort: fetch key, walk down while predecessor is smaller
        S_SO_KEY: begin
          if (i_q >= count_q) begin ok_q <= 1'b1; state_q <= S_DONE; end
          else begin j_q <= i_q; state_q <= S_SO_CMP; end
        end
        S_SO_CMP: begin
          if (j_q == i_q) key_q <= rdata_q;
          state_q <= S_SO_WR;
        end
        S_SO_WR: begin
          // rdata_q holds entry j-1: shifted up into j, else the key lands at j
          if (so_shift) begin
            j_q <= j_q - CW'(1); state_q <= S_SO_CMP;
          end else begin
            i_q <= i_q + CW'(1); state_q <= S_SO_KEY;
          end
        end
        S_DONE: begin
          if (func_q == bvs_pkg::FUNC_READ && ok_q) rdo_q <= rdata_q;
          done_q <= 1'b1; state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy   = (state_q != S_IDLE) || done_q;
  assign done_o = done_q;
  assign rsp_o  = '{ok: ok_q, data_out: rdo_q, entries_used: 9'(count_q)};
endmodule

FILE: hdl/bvs_checker.sv
// ----------------------------------------------------------------------------
// bvs_checker
// Port-level checks on the bounded list with sort.
// ----------------------------------------------------------------------------
`include "bounded_vector_with_sort_macros.svh"
module bvs_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input logic          done_o,
  input bvs_pkg::rsp_t rsp_o
);
  `BVS_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o, "done repeated")
  `BVS_ASSERT_IMP(a_busy_done, clk_i, rst_ni, done_o, busy, "done while idle")
  `BVS_ASSERT(a_acc_busy, clk_i, rst_ni, (start && !busy) |=> busy, "not busy after request")
  `BVS_ASSERT_IMP(a_cnt_cap, clk_i, rst_ni, done_o, rsp_o.entries_used <= 9'd256, "count high")
  `BVS_ASSERT_IMP(a_fail_zero, clk_i, rst_ni, done_o && !rsp_o.ok, rsp_o.data_out == 0, "fail data")
endmodule

bind bounded_vector_with_sort bvs_checker u_bvs_checker (.*);
